@@ sv/drrip_stream_dead_block_replacement_macros.svh @@
// assertion macros used by the checker file
`ifndef DRRIP_STREAM_DEAD_BLOCK_REPLACEMENT_MACROS_SVH
`define DRRIP_STREAM_DEAD_BLOCK_REPLACEMENT_MACROS_SVH

// property clocked on clk_i, off while reset is low
`define DRR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication, same clock and reset
`define DRR_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

`endif

@@ sv/drr_pkg.sv @@
// package: sizes, word and row types, leader tests
package drr_pkg;

  localparam int NUM_SETS     = 2048;
  localparam int NUM_WAYS     = 16;
  localparam int WINDOW_LEN   = 8;
  localparam int LEADER_COUNT = 32;

  localparam int SET_W   = $clog2(NUM_SETS);
  localparam int WAY_W   = $clog2(NUM_WAYS);
  localparam int PTR_W   = $clog2(WINDOW_LEN);
  localparam int CNT_W   = $clog2(WINDOW_LEN + 1);
  localparam int THR_W   = 4;
  localparam int CMP_W   = CNT_W + THR_W;
  localparam int PSEL_W  = 10;
  localparam int UCNT_W  = 16;
  localparam int LEADER_GAP = (NUM_SETS / LEADER_COUNT) > 0 ? (NUM_SETS / LEADER_COUNT) : 1;

  localparam logic [1:0] RRPV_TOP = 2'd3;
  localparam logic [1:0] DEAD_TOP = 2'd3;
  localparam logic [1:0] RRPV_MID = 2'd2;
  localparam logic [PSEL_W-1:0] SEL_TOP = PSEL_W'(1023);
  localparam logic [PSEL_W-1:0] SEL_MID = PSEL_W'(511);
  localparam logic [THR_W-1:0]  THR_RESET = THR_W'(6);
  localparam logic [UCNT_W-1:0] DECAY_RESET = UCNT_W'(4096);

  // register indexes on the configuration port
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_DECAY     = 1'b1;

  typedef enum logic [0:0] {
    OP_QUERY  = 1'b0,
    OP_UPDATE = 1'b1
  } drr_op_e;

  typedef struct packed {
    logic        op;
    logic [10:0] set_index;
    logic [3:0]  way_index;
    logic [63:0] phys_addr;
    logic        was_hit;
  } drr_in_t;

  typedef struct packed {
    logic [3:0] victim_way;
    logic [1:0] written_rrpv;
    logic       set_streaming;
    logic [9:0] policy_select;
  } drr_out_t;

  // one memory row holds all per-set state
  typedef struct packed {
    logic [NUM_WAYS-1:0][1:0]   rrpv;
    logic [NUM_WAYS-1:0][1:0]   dead;
    logic [63:0]                last;
    logic [WINDOW_LEN-1:0][7:0] win;
    logic [PTR_W-1:0]           ptr;
    logic                       flag;
  } drr_row_t;

  typedef struct packed {
    logic             we;
    logic [SET_W-1:0] waddr;
    logic             re;
    logic [SET_W-1:0] raddr;
  } drr_ram_req_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DEC_RD,
    ST_DEC_WR,
    ST_RD,
    ST_LOAD,
    ST_AGE,
    ST_CNT,
    ST_APPLY,
    ST_DONE
  } drr_state_e;

  function automatic logic srrip_leader(input logic [SET_W-1:0] s);
    return (s % LEADER_GAP) == 0;
  endfunction

  function automatic logic brrip_leader(input logic [SET_W-1:0] s);
    return (s % LEADER_GAP) == (LEADER_GAP / 2);
  endfunction

endpackage

@@ sv/drrip_stream_dead_block_replacement.sv @@
// DRRIP replacement policy with stream detector and dead-block counters
//
// Input channel in_valid_i/in_ready_o carries one word per access: a victim
// query (op 0) or a replacement state update (op 1). Output channel
// out_valid_o/out_ready_i returns one result word per input word.
// Configuration goes over the APB port: the stream match threshold at 0x0,
// decay_interval at 0x4; the user writes them only while the block is idle,
// which the block itself does not enforce. One word is handled at a time.
// All per-set state sits in one memory row that is read, worked on in a row
// register and written back. A query ages the set (0 to 3 ageing passes)
// until a way sits at the top rrpv. An update's stream count walks the 8 window
// slots one per cycle through a shared compare and popcount unit. An update that
// triggers the global decay first sweeps all 2048 rows, each read in ST_DEC_RD
// and written back in ST_DEC_WR.
// After reset a clearing pass writes the reset row to all 2048 sets, one
// per cycle; no word is accepted meanwhile, configuration writes are.
// The result sits in an output register; a new word is taken while it waits,
// and a finished result waits in its state until the register frees up.
module drrip_stream_dead_block_replacement (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  drr_pkg::drr_in_t in_word_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output drr_pkg::drr_out_t out_word_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  drr_pkg::drr_state_e state_q, state_d;
  drr_pkg::drr_in_t    item_q, item_d;
  drr_pkg::drr_row_t   row_q, row_d;
  drr_pkg::drr_out_t   res_q, res_d;
  drr_pkg::drr_out_t   out_q, out_d;
  logic                out_valid_q, out_valid_d;
  logic [drr_pkg::SET_W-1:0]  cnt_q, cnt_d;
  logic [drr_pkg::PTR_W-1:0]  slot_q, slot_d;
  logic                       any_q, any_d;
  logic [7:0]                 delta_q, delta_d;
  logic [drr_pkg::PSEL_W-1:0] psel_q, psel_d;
  logic [drr_pkg::UCNT_W-1:0] ucnt_q, ucnt_d;
  logic [drr_pkg::THR_W-1:0]  thr_q;
  logic [drr_pkg::UCNT_W-1:0] decay_q;

  drr_pkg::drr_ram_req_t ram_req;
  drr_pkg::drr_row_t     ram_wdata, ram_rdata;

  logic [drr_pkg::SET_W-1:0] set_idx;
  logic [drr_pkg::WAY_W-1:0] way_idx;
  logic [drr_pkg::UCNT_W-1:0] ucnt_inc;

  // shared units on the row register and on the row just read
  logic                       found;
  logic [drr_pkg::WAY_W-1:0]  first_way;
  drr_pkg::drr_row_t          aged_row, decayed_row, tracked_row, clear_row;
  logic [drr_pkg::CNT_W-1:0]  match_cnt;
  logic [7:0]                 new_delta;
  logic                       new_flag;
  logic [1:0]                 dead_inc;

  assign set_idx  = item_q.set_index[drr_pkg::SET_W-1:0];
  assign way_idx  = item_q.way_index[drr_pkg::WAY_W-1:0];
  assign ucnt_inc = ucnt_q + drr_pkg::UCNT_W'(1);

  drr_set_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // apb register file
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= drr_pkg::THR_RESET;
      decay_q <= drr_pkg::DECAY_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == drr_pkg::REG_THRESHOLD) begin
        thr_q <= pwdata[drr_pkg::THR_W-1:0];
      end else begin
        decay_q <= pwdata[drr_pkg::UCNT_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == drr_pkg::REG_DECAY) begin
      prdata = {16'd0, decay_q};
    end else begin
      prdata = {28'd0, thr_q};
    end
  end

  // first way at the top rrpv, and one ageing pass
  always_comb begin
    found     = 1'b0;
    first_way = '0;
    aged_row  = row_q;
    for (int w = drr_pkg::NUM_WAYS - 1; w >= 0; w--) begin
      if (row_q.rrpv[w] == drr_pkg::RRPV_TOP) begin
        found     = 1'b1;
        first_way = drr_pkg::WAY_W'(w);
      end else begin
        aged_row.rrpv[w] = row_q.rrpv[w] + 2'd1;
      end
    end
  end

  // decay of every dead counter in the row just read
  always_comb begin
    decayed_row = ram_rdata;
    for (int w = 0; w < drr_pkg::NUM_WAYS; w++) begin
      if (ram_rdata.dead[w] != 2'd0) begin
        decayed_row.dead[w] = ram_rdata.dead[w] - 2'd1;
      end
    end
  end

  // reset row
  always_comb begin
    clear_row      = '0;
    clear_row.rrpv = '1;
  end

  // line delta and window write on the row just read
  always_comb begin
    if (ram_rdata.last == 64'd0) begin
      new_delta = 8'd0;
    end else begin
      new_delta = item_q.phys_addr[13:6] - ram_rdata.last[13:6];
    end
    tracked_row      = ram_rdata;
    tracked_row.last = item_q.phys_addr;
    tracked_row.win[ram_rdata.ptr] = new_delta;
    if (ram_rdata.ptr == drr_pkg::PTR_W'(drr_pkg::WINDOW_LEN - 1)) begin
      tracked_row.ptr = '0;
    end else begin
      tracked_row.ptr = ram_rdata.ptr + drr_pkg::PTR_W'(1);
    end
  end

  // matches of one window slot against the whole window
  always_comb begin
    match_cnt = '0;
    for (int j = 0; j < drr_pkg::WINDOW_LEN; j++) begin
      if (row_q.win[j] == row_q.win[slot_q]) begin
        match_cnt = match_cnt + drr_pkg::CNT_W'(1);
      end
    end
  end

  assign new_flag = any_q && (delta_q != 8'd0);
  assign dead_inc = (row_q.dead[way_idx] < drr_pkg::DEAD_TOP) ?
                    row_q.dead[way_idx] + 2'd1 : row_q.dead[way_idx];

  // sequencer
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    row_d       = row_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    cnt_d       = cnt_q;
    slot_d      = slot_q;
    any_d       = any_q;
    delta_d     = delta_q;
    psel_d      = psel_q;
    ucnt_d      = ucnt_q;
    in_ready_o  = 1'b0;
    ram_req     = '0;
    ram_wdata   = row_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      drr_pkg::ST_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cnt_q;
        ram_wdata     = clear_row;
        cnt_d         = cnt_q + drr_pkg::SET_W'(1);
        if (cnt_q == drr_pkg::SET_W'(drr_pkg::NUM_SETS - 1)) begin
          state_d = drr_pkg::ST_IDLE;
        end
      end
      drr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d  = in_word_i;
          state_d = drr_pkg::ST_RD;
          if (in_word_i.op == drr_pkg::OP_UPDATE) begin
            ucnt_d = ucnt_inc;
            if (ucnt_inc == decay_q) begin
              ucnt_d  = '0;
              cnt_d   = '0;
              state_d = drr_pkg::ST_DEC_RD;
            end
          end
        end
      end
      drr_pkg::ST_DEC_RD: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = cnt_q;
        state_d       = drr_pkg::ST_DEC_WR;
      end
      drr_pkg::ST_DEC_WR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cnt_q;
        ram_wdata     = decayed_row;
        cnt_d         = cnt_q + drr_pkg::SET_W'(1);
        if (cnt_q == drr_pkg::SET_W'(drr_pkg::NUM_SETS - 1)) begin
          state_d = drr_pkg::ST_RD;
        end else begin
          state_d = drr_pkg::ST_DEC_RD;
        end
      end
      drr_pkg::ST_RD: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = set_idx;
        state_d       = drr_pkg::ST_LOAD;
      end
      drr_pkg::ST_LOAD: begin
        if (item_q.op == drr_pkg::OP_QUERY) begin
          row_d   = ram_rdata;
          state_d = drr_pkg::ST_AGE;
        end else begin
          row_d   = tracked_row;
          delta_d = new_delta;
          slot_d  = '0;
          any_d   = 1'b0;
          state_d = drr_pkg::ST_CNT;
        end
      end
      drr_pkg::ST_AGE: begin
        if (found) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = set_idx;
          res_d.victim_way    = 4'(first_way);
          res_d.written_rrpv  = 2'd0;
          res_d.set_streaming = row_q.flag;
          res_d.policy_select = psel_q;
          state_d = drr_pkg::ST_DONE;
        end else begin
          row_d = aged_row;
        end
      end
      drr_pkg::ST_CNT: begin
        if (drr_pkg::CMP_W'(match_cnt) >= drr_pkg::CMP_W'(thr_q)) begin
          any_d = 1'b1;
        end
        slot_d = slot_q + drr_pkg::PTR_W'(1);
        if (slot_q == drr_pkg::PTR_W'(drr_pkg::WINDOW_LEN - 1)) begin
          state_d = drr_pkg::ST_APPLY;
        end
      end
      drr_pkg::ST_APPLY: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = set_idx;
        ram_wdata.flag = new_flag;
        res_d.victim_way    = 4'd0;
        res_d.set_streaming = new_flag;
        if (item_q.was_hit) begin
          ram_wdata.rrpv[way_idx] = 2'd0;
          ram_wdata.dead[way_idx] = 2'd0;
          res_d.written_rrpv      = 2'd0;
          if (drr_pkg::srrip_leader(set_idx) && psel_q < drr_pkg::SEL_TOP) begin
            psel_d = psel_q + drr_pkg::PSEL_W'(1);
          end else if (drr_pkg::brrip_leader(set_idx) && psel_q != '0) begin
            psel_d = psel_q - drr_pkg::PSEL_W'(1);
          end
        end else if (new_flag) begin
          ram_wdata.rrpv[way_idx] = drr_pkg::RRPV_TOP;
          ram_wdata.dead[way_idx] = drr_pkg::DEAD_TOP;
          res_d.written_rrpv      = drr_pkg::RRPV_TOP;
        end else begin
          // dead counter is at least one after the increment: always rrpv 2
          ram_wdata.rrpv[way_idx] = (dead_inc != 2'd0) ? drr_pkg::RRPV_MID :
            ((drr_pkg::srrip_leader(set_idx) ||
              (!drr_pkg::brrip_leader(set_idx) && psel_q >= drr_pkg::SEL_MID)) ?
             2'd0 : drr_pkg::RRPV_MID);
          ram_wdata.dead[way_idx] = 2'd0;
          res_d.written_rrpv      = ram_wdata.rrpv[way_idx];
        end
        res_d.policy_select = psel_d;
        state_d = drr_pkg::ST_DONE;
      end
      drr_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = drr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = drr_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= drr_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      slot_q      <= '0;
      any_q       <= 1'b0;
      psel_q      <= drr_pkg::SEL_MID;
      ucnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      slot_q      <= slot_d;
      any_q       <= any_d;
      psel_q      <= psel_d;
      ucnt_q      <= ucnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    row_q   <= row_d;
    res_q   <= res_d;
    out_q   <= out_d;
    delta_q <= delta_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

@@ sv/drr_set_ram.sv @@
// per-set state memory, one write and one registered read port
module drr_set_ram (
  input  logic                  clk_i,
  input  drr_pkg::drr_ram_req_t req_i,
  input  drr_pkg::drr_row_t     wdata_i,
  output drr_pkg::drr_row_t     rdata_o
);

  drr_pkg::drr_row_t mem_q [drr_pkg::NUM_SETS];

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_o <= mem_q[req_i.raddr];
    end
  end

endmodule

@@ sv/drr_checker.sv @@
// port-level checker for the replacement policy block, with its bind
`include "drrip_stream_dead_block_replacement_macros.svh"

module drr_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input drr_pkg::drr_out_t out_word_o
);

  // a stalled result word holds
  `DRR_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o), "result word changed while stalled")

  // one word at a time: not ready right after an accept
  `DRR_ASSERT(a_one_at_a_time, in_valid_i && in_ready_o |=> !in_ready_o, "ready right after an accept")

  // rrpv 1 is never written
  `DRR_ASSERT_IMP(a_no_rrpv_one, out_valid_o, out_word_o.written_rrpv != 2'd1, "rrpv 1 in a result")

  // distant insertion only for a streaming set
  `DRR_ASSERT_IMP(a_top_streams, out_valid_o && out_word_o.written_rrpv == 2'd3, out_word_o.set_streaming, "rrpv 3 without stream flag")

endmodule

bind drrip_stream_dead_block_replacement drr_checker u_drr_checker (.*);
